>>> hdl/jsc_pkg.sv
// jsc_pkg: shared types, character codes and literal tables for the lax json checker
// no dependencies; used by jsc_stack, jsc_core, the top and both testbenches
`default_nettype none

package jsc_pkg;

    // default nesting depth of the container stack
    localparam int unsigned DEF_MAX_DEPTH = 64;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_LOWER_E   = 8'h65;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // literal_step start points for true, false, null
    localparam logic [3:0] LIT_TRUE  = 4'd1;
    localparam logic [3:0] LIT_FALSE = 4'd4;
    localparam logic [3:0] LIT_NULL  = 4'd8;
    localparam logic [3:0] LIT_END   = 4'd10;

    typedef enum logic [3:0] {
        M_VALUE      = 4'd0,
        M_ARR_ELEM   = 4'd1,
        M_OBJ_KEY    = 4'd2,
        M_KEY_STR    = 4'd3,
        M_COLON      = 4'd4,
        M_VAL_STR    = 4'd5,
        M_AFTER_RAW  = 4'd6,
        M_AFTER_SKIP = 4'd7,
        M_LITERAL    = 4'd8,
        M_NUMBER     = 4'd9
    } t_mode;

    typedef enum logic [1:0] {
        V_UNDECIDED = 2'd0,
        V_VALID     = 2'd1,
        V_INVALID   = 2'd2,
        V_DEEP      = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_INVALID = 2'd1,
        ST_DEEP    = 2'd2
    } t_status;

    // container stack request from the parser
    typedef struct packed {
        logic push;
        logic pop;
        logic kind;   // 1 object, 0 array
    } t_stack_cmd;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_num_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || c == CH_DOT || c == CH_LOWER_E
            || c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // expected letter at each literal step (rue, alse, ull)
    function automatic logic [7:0] lit_char(input logic [3:0] step);
        logic [7:0] c;
        case (step)
            4'd1:    c = 8'h72;
            4'd2:    c = 8'h75;
            4'd3:    c = 8'h65;
            4'd4:    c = 8'h61;
            4'd5:    c = 8'h6C;
            4'd6:    c = 8'h73;
            4'd7:    c = 8'h65;
            4'd8:    c = 8'h75;
            4'd9:    c = 8'h6C;
            4'd10:   c = 8'h6C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic lit_last(input logic [3:0] step);
        return step == 4'd3 || step == 4'd7 || step == 4'd10;
    endfunction

endpackage

`default_nettype wire

>>> hdl/jsc_byte_if.sv
// jsc_byte_if: text byte channel, valid/ready with byte and last flag
// no dependencies
`default_nettype none

interface jsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

>>> hdl/jsc_status_if.sv
// jsc_status_if: status channel, valid/ready with 2-bit status
// no dependencies
`default_nettype none

interface jsc_status_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

>>> hdl/jsc_stack.sv
// jsc_stack: container kind stack, memory plus cached top and prefetched entry below
// depends on jsc_pkg
`default_nettype none

module jsc_stack
    import jsc_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic [$clog2(MAX_DEPTH + 1)-1:0] i_wr_level,
    input  wire logic [$clog2(MAX_DEPTH + 1)-1:0] i_next_level,
    input  wire t_stack_cmd                       i_cmd,
    output logic                                  o_top
);

    localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic            r_mem [MAX_DEPTH];
    logic            r_top;
    logic            n_top;
    logic            r_below;
    logic [AW-1:0]   rd_addr;

    // entry under the next top, so a pop finds its new top ready
    always_comb begin
        if (32'(i_next_level) >= 32'd2) begin
            rd_addr = AW'(32'(i_next_level) - 32'd2);
        end else begin
            rd_addr = '0;
        end
    end

    always_comb begin
        n_top = r_top;
        if (i_cmd.push) begin
            n_top = i_cmd.kind;
        end else if (i_cmd.pop) begin
            n_top = r_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[AW'(i_wr_level)] <= i_cmd.kind;
        end
        r_below <= r_mem[rd_addr];
        r_top   <= n_top;
    end

    assign o_top = r_top;

endmodule

`default_nettype wire

>>> hdl/jsc_core.sv
// jsc_core: parse mode, literal and escape tracking, nesting level and verdict
// depends on jsc_pkg and jsc_stack
`default_nettype none

module jsc_core
    import jsc_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_status         o_status
);

    localparam int unsigned LW = $clog2(MAX_DEPTH + 1);

    t_mode          r_mode,    n_mode;
    logic [3:0]     r_lit,     n_lit;
    logic           r_esc,     n_esc;
    logic [LW-1:0]  r_level,   n_level;
    t_verdict       r_verdict, n_verdict;
    t_verdict       byte_verdict;
    t_stack_cmd     cmd;
    logic           top_kind;
    logic           want_start;
    logic           want_after;
    logic           want_close;
    logic           str_close;

    jsc_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .i_clk        (i_clk),
        .i_wr_level   (r_level),
        .i_next_level (n_level),
        .i_cmd        (cmd),
        .o_top        (top_kind)
    );

    // string byte: escaped byte passes, quote closes, backslash arms escape
    always_comb begin
        str_close = !r_esc && (i_byte == CH_QUOTE);
    end

    always_comb begin
        n_mode     = r_mode;
        n_lit      = r_lit;
        n_esc      = r_esc;
        n_level    = r_level;
        n_verdict  = r_verdict;
        cmd        = '0;
        want_start = 1'b0;
        want_after = 1'b0;
        want_close = 1'b0;

        if (i_take && r_verdict == V_UNDECIDED) begin
            case (r_mode)
                M_VALUE: begin
                    want_start = !is_blank(i_byte);
                end
                M_ARR_ELEM: begin
                    if (!is_blank(i_byte)) begin
                        if (i_byte == CH_RBRACKET) begin
                            want_close = 1'b1;
                        end else begin
                            want_start = 1'b1;
                        end
                    end
                end
                M_OBJ_KEY: begin
                    if (!is_blank(i_byte)) begin
                        if (i_byte == CH_RBRACE) begin
                            want_close = 1'b1;
                        end else if (i_byte == CH_QUOTE) begin
                            n_esc  = 1'b0;
                            n_mode = M_KEY_STR;
                        end else begin
                            n_verdict = V_INVALID;
                        end
                    end
                end
                M_KEY_STR: begin
                    n_esc = !r_esc && (i_byte == CH_BACKSLASH);
                    if (str_close) begin
                        n_mode = M_COLON;
                    end
                end
                M_COLON: begin
                    if (i_byte == CH_COLON) begin
                        n_mode = M_VALUE;
                    end else begin
                        n_verdict = V_INVALID;
                    end
                end
                M_VAL_STR: begin
                    n_esc = !r_esc && (i_byte == CH_BACKSLASH);
                    if (str_close) begin
                        if (r_level == '0) begin
                            n_verdict = V_VALID;
                        end else begin
                            n_mode = M_AFTER_RAW;
                        end
                    end
                end
                M_AFTER_RAW: begin
                    want_after = 1'b1;
                end
                M_AFTER_SKIP: begin
                    want_after = !is_blank(i_byte);
                end
                M_LITERAL: begin
                    if (!is_blank(i_byte)) begin
                        if (r_lit == 4'd0 || r_lit > LIT_END || i_byte != lit_char(r_lit)) begin
                            n_verdict = V_INVALID;
                        end else if (lit_last(r_lit)) begin
                            n_lit = 4'd0;
                            if (r_level == '0) begin
                                n_verdict = V_VALID;
                            end else begin
                                n_mode = M_AFTER_SKIP;
                            end
                        end else begin
                            n_lit = r_lit + 4'd1;
                        end
                    end
                end
                M_NUMBER: begin
                    want_after = !(is_blank(i_byte) || is_num_char(i_byte));
                end
                default: begin
                    n_verdict = V_INVALID;
                end
            endcase
        end

        // separator or closer after a finished value
        if (want_after) begin
            if (r_level == '0) begin
                n_verdict = V_INVALID;
            end else if (i_byte == CH_COMMA) begin
                n_mode = top_kind ? M_OBJ_KEY : M_ARR_ELEM;
            end else if (i_byte == (top_kind ? CH_RBRACE : CH_RBRACKET)) begin
                want_close = 1'b1;
            end else begin
                n_verdict = V_INVALID;
            end
        end

        if (want_close) begin
            if (r_level == '0) begin
                n_verdict = V_INVALID;
            end else begin
                cmd.pop = 1'b1;
                n_level = r_level - LW'(1);
                if (r_level == LW'(1)) begin
                    n_verdict = V_VALID;
                end else begin
                    n_mode = M_AFTER_SKIP;
                end
            end
        end

        if (want_start) begin
            if (i_byte == CH_LBRACE || i_byte == CH_LBRACKET) begin
                if (r_level >= LW'(MAX_DEPTH)) begin
                    n_verdict = V_DEEP;
                end else begin
                    cmd.push = 1'b1;
                    cmd.kind = (i_byte == CH_LBRACE);
                    n_level  = r_level + LW'(1);
                    n_mode   = (i_byte == CH_LBRACE) ? M_OBJ_KEY : M_ARR_ELEM;
                end
            end else if (i_byte == CH_QUOTE) begin
                n_esc  = 1'b0;
                n_mode = M_VAL_STR;
            end else if (i_byte == CH_LOWER_T || i_byte == CH_LOWER_F
                         || i_byte == CH_LOWER_N) begin
                n_lit  = (i_byte == CH_LOWER_T) ? LIT_TRUE
                       : (i_byte == CH_LOWER_F) ? LIT_FALSE : LIT_NULL;
                n_mode = M_LITERAL;
            end else if (i_byte == CH_MINUS || is_digit(i_byte)) begin
                if (r_level == '0) begin
                    n_verdict = V_VALID;
                end else begin
                    n_mode = M_NUMBER;
                end
            end else begin
                n_verdict = V_INVALID;
            end
        end

        byte_verdict = n_verdict;

        // last byte ends the document, back to the reset state
        if (i_take && i_last) begin
            n_mode    = M_VALUE;
            n_lit     = 4'd0;
            n_esc     = 1'b0;
            n_level   = '0;
            n_verdict = V_UNDECIDED;
        end
    end

    always_comb begin
        case (byte_verdict)
            V_VALID: o_status = ST_VALID;
            V_DEEP:  o_status = ST_DEEP;
            default: o_status = ST_INVALID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_VALUE;
            r_lit     <= 4'd0;
            r_esc     <= 1'b0;
            r_level   <= '0;
            r_verdict <= V_UNDECIDED;
        end else begin
            r_mode    <= n_mode;
            r_lit     <= n_lit;
            r_esc     <= n_esc;
            r_level   <= n_level;
            r_verdict <= n_verdict;
        end
    end

    a_doc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_last |=> r_level == '0 && r_verdict == V_UNDECIDED && r_mode == M_VALUE)
        else $error("state not cleared after last byte");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |=> $stable(r_verdict) && $stable(r_level) && $stable(r_mode))
        else $error("parse state moved without an item");

    a_level_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && !i_last |=> 32'(r_level) == 32'($past(r_level))
            || 32'(r_level) == 32'($past(r_level)) + 32'd1
            || 32'(r_level) + 32'd1 == 32'($past(r_level)))
        else $error("nesting level moved by more than one");

endmodule

`default_nettype wire

>>> hdl/lax_json_syntax_checker_top.sv
// lax_json_syntax_checker_top: input register, parser core and status register
// depends on jsc_pkg, jsc_byte_if, jsc_status_if, jsc_core
//
// usage
//   i_text carries one document byte per item; end_of_text marks the last byte
//   of a document. o_status carries one item per document, issued for the last
//   byte: 0 valid, 1 syntax invalid, 2 nesting deeper than MAX_DEPTH.
//   bytes without end_of_text give no status item.
// timing
//   one byte per cycle sustained while no last byte waits on the status
//   receiver. an accepted byte sits in the input register, is parsed as it
//   leaves it and its status (if any) is registered at that edge. the parse
//   step is one pass of mode decode, the cached stack top and one compare;
//   the entry under the top is prefetched every cycle, so closers never wait.
// reset
//   i_rst_n is synchronous, active low: parse state returns to expecting the
//   first value, nesting level zero, both channels empty. the stack memory is
//   not cleared; only entries below the current level are ever used.
// stall
//   if the status receiver holds off, a last byte waits in the input register
//   and i_text.ready drops once that register is full; ordinary bytes before it
//   still flow through the parser while the receiver holds off.
`default_nettype none

module lax_json_syntax_checker_top
    import jsc_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    jsc_byte_if.sink      i_text,
    jsc_status_if.source  o_status
);

    // input register
    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;
    // result register
    logic        r_out_valid;
    t_status     r_out_status;

    logic        s1_take;
    logic        in_fire;
    t_status     core_status;

    // a last byte needs a free result slot, other bytes just pass
    assign s1_take = r_s1_valid && (!r_s1_last || !r_out_valid || o_status.ready);
    assign i_text.ready = !r_s1_valid || s1_take;
    assign in_fire = i_text.valid && i_text.ready;

    jsc_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (s1_take),
        .i_byte   (r_s1_byte),
        .i_last   (r_s1_last),
        .o_status (core_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    // payload of the input register, loaded on each accepted item
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte <= i_text.text_byte;
            r_s1_last <= i_text.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_take && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_status.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && r_s1_last) begin
            r_out_status <= core_status;
        end
    end

    assign o_status.valid  = r_out_valid;
    assign o_status.status = r_out_status;

    a_last_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_take && r_s1_last |=> r_out_valid)
        else $error("last byte parsed but no status item");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_status.ready |-> !(s1_take && r_s1_last))
        else $error("pending status item overwritten");

    a_stalled_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_last && r_out_valid && !o_status.ready |-> !i_text.ready)
        else $error("input accepted while a last byte is stuck");

endmodule

`default_nettype wire

>>> sim/tb_jsc_status_checker.sv
`timescale 1ns / 100ps
// tb_jsc_status_checker: watches the text and status channels, predicts each status item
// depends on jsc_pkg, jsc_byte_if, jsc_status_if

module tb_jsc_status_checker
    import jsc_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    jsc_byte_if   i_text,
    jsc_status_if i_status,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_valid_seen,
    output int    o_invalid_seen,
    output int    o_deep_seen
);

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;

    // parser copy: mode, literal position, escape flag, container stack, verdict
    t_mode       mode_q;
    logic [3:0]  lit_pos;
    logic        esc_q;
    logic        kind_stack [MAX_DEPTH];
    int unsigned depth_q;
    t_verdict    verdict_q;

    // letters of true/false/null, indexed by literal position
    string lit_letters = "xruealseull";

    t_status status_expected [$];

    function automatic logic blank_byte(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic number_byte(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_LOWER_E
            || c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic void reset_parser();
        mode_q    = M_VALUE;
        lit_pos   = '0;
        esc_q     = 1'b0;
        depth_q   = 0;
        verdict_q = V_UNDECIDED;
        for (int i = 0; i < MAX_DEPTH; i++) kind_stack[i] = 1'b0;
    endfunction

    function automatic void value_complete(input t_mode next_mode);
        if (depth_q == 0) verdict_q = V_VALID;
        else mode_q = next_mode;
    endfunction

    function automatic void close_container();
        if (depth_q == 0) begin
            verdict_q = V_INVALID;
        end else begin
            depth_q--;
            value_complete(M_AFTER_SKIP);
        end
    endfunction

    function automatic void open_container(input logic is_obj, input t_mode next_mode);
        if (depth_q >= MAX_DEPTH) begin
            verdict_q = V_DEEP;
        end else begin
            kind_stack[depth_q] = is_obj;
            depth_q++;
            mode_q = next_mode;
        end
    endfunction

    // separator or closer after a complete value inside a container
    function automatic void follow_value(input logic [7:0] c);
        logic is_obj;
        if (depth_q == 0) begin
            verdict_q = V_INVALID;
            return;
        end
        is_obj = kind_stack[depth_q - 1];
        if (c == CH_COMMA) mode_q = is_obj ? M_OBJ_KEY : M_ARR_ELEM;
        else if (c == (is_obj ? CH_RBRACE : CH_RBRACKET)) close_container();
        else verdict_q = V_INVALID;
    endfunction

    function automatic void begin_value(input logic [7:0] c);
        if (c == CH_LBRACE) begin
            open_container(1'b1, M_OBJ_KEY);
        end else if (c == CH_LBRACKET) begin
            open_container(1'b0, M_ARR_ELEM);
        end else if (c == CH_QUOTE) begin
            esc_q  = 1'b0;
            mode_q = M_VAL_STR;
        end else if (c == CH_LOWER_T || c == CH_LOWER_F || c == CH_LOWER_N) begin
            lit_pos = (c == CH_LOWER_T) ? LIT_TRUE : (c == CH_LOWER_F) ? LIT_FALSE : LIT_NULL;
            mode_q  = M_LITERAL;
        end else if (c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE)) begin
            value_complete(M_NUMBER);
        end else begin
            verdict_q = V_INVALID;
        end
    endfunction

    // returns 1 on the closing quote
    function automatic logic string_closes(input logic [7:0] c);
        if (esc_q) begin
            esc_q = 1'b0;
            return 1'b0;
        end
        if (c == CH_QUOTE) return 1'b1;
        esc_q = (c == CH_BACKSLASH);
        return 1'b0;
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        case (mode_q)
            M_VALUE: begin
                if (!blank_byte(c)) begin_value(c);
            end
            M_ARR_ELEM: begin
                if (!blank_byte(c)) begin
                    if (c == CH_RBRACKET) close_container();
                    else begin_value(c);
                end
            end
            M_OBJ_KEY: begin
                if (!blank_byte(c)) begin
                    if (c == CH_RBRACE) begin
                        close_container();
                    end else if (c == CH_QUOTE) begin
                        esc_q  = 1'b0;
                        mode_q = M_KEY_STR;
                    end else begin
                        verdict_q = V_INVALID;
                    end
                end
            end
            M_KEY_STR: begin
                if (string_closes(c)) mode_q = M_COLON;
            end
            M_COLON: begin
                if (c == CH_COLON) mode_q = M_VALUE;
                else verdict_q = V_INVALID;
            end
            M_VAL_STR: begin
                if (string_closes(c)) value_complete(M_AFTER_RAW);
            end
            M_AFTER_RAW: begin
                follow_value(c);
            end
            M_AFTER_SKIP: begin
                if (!blank_byte(c)) follow_value(c);
            end
            M_LITERAL: begin
                if (!blank_byte(c)) begin
                    if (lit_pos == 0 || lit_pos > LIT_END || c != lit_letters[lit_pos]) begin
                        verdict_q = V_INVALID;
                    end else if (lit_pos == LIT_TRUE + 4'd2 || lit_pos == LIT_NULL - 4'd1
                                 || lit_pos == LIT_END) begin
                        lit_pos = '0;
                        value_complete(M_AFTER_SKIP);
                    end else begin
                        lit_pos++;
                    end
                end
            end
            M_NUMBER: begin
                if (!blank_byte(c) && !number_byte(c)) follow_value(c);
            end
            default: begin
                verdict_q = V_INVALID;
            end
        endcase
    endfunction

    // one text byte in; returns 1 with the status when the byte ends a document
    function automatic logic consume_byte(input logic [7:0] c, input logic last,
                                          output t_status st);
        st = ST_INVALID;
        if (verdict_q == V_UNDECIDED) parse_byte(c);
        if (!last) return 1'b0;
        case (verdict_q)
            V_VALID: st = ST_VALID;
            V_DEEP:  st = ST_DEEP;
            default: st = ST_INVALID;
        endcase
        reset_parser();
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_status predicted;
        t_status wanted;
        if (!i_rst_n) begin
            reset_parser();
            status_expected.delete();
            o_fail_count   = 0;
            o_pending      = 0;
            o_valid_seen   = 0;
            o_invalid_seen = 0;
            o_deep_seen    = 0;
        end else begin
            if (i_text.valid && i_text.ready) begin
                if (consume_byte(i_text.text_byte, i_text.end_of_text, predicted))
                    status_expected = {status_expected, predicted};
            end
            if (i_status.valid && i_status.ready) begin
                case (i_status.status)
                    ST_VALID: o_valid_seen++;
                    ST_DEEP:  o_deep_seen++;
                    default:  o_invalid_seen++;
                endcase
                if (status_expected.size() == 0) begin
                    $display("%0t: status item %0d arrived with none expected",
                             $time, i_status.status);
                    o_fail_count++;
                end else begin
                    wanted = status_expected.pop_front();
                    if (i_status.status !== wanted) begin
                        $display("%0t: status mismatch, expected %0d (%s), actual %0d",
                                 $time, wanted, wanted.name(), i_status.status);
                        o_fail_count++;
                    end
                end
            end
            o_pending = status_expected.size();
        end
    end

endmodule

>>> sim/tb_lax_json_syntax_checker_top.sv
`timescale 1ns / 100ps
// tb_lax_json_syntax_checker_top: document stimulus, status stalls and final verdict
// depends on jsc_pkg, both channel interfaces, lax_json_syntax_checker_top, tb_jsc_status_checker

module tb_lax_json_syntax_checker_top;
    import jsc_pkg::*;

    localparam int unsigned NEST_LIMIT = DEF_MAX_DEPTH;
    // random part stops once this many bytes have gone in
    localparam int unsigned RANDOM_BYTES = 1600;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [7:0] TOP_BYTE  = 8'hFF;

    logic clk;
    logic rst_n;

    jsc_byte_if   text_bus ();
    jsc_status_if status_bus ();

    int fail_count;
    int pending;
    int valid_seen;
    int invalid_seen;
    int deep_seen;

    lax_json_syntax_checker_top #(
        .MAX_DEPTH (NEST_LIMIT)
    ) dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_text   (text_bus),
        .o_status (status_bus)
    );

    // predicts every status item from the accepted bytes and counts mismatches
    tb_jsc_status_checker #(
        .MAX_DEPTH (NEST_LIMIT)
    ) status_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_text         (text_bus),
        .i_status       (status_bus),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_valid_seen   (valid_seen),
        .o_invalid_seen (invalid_seen),
        .o_deep_seen    (deep_seen)
    );

    // 8 ns clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop, several times the slowest legal run
    initial begin
        #7_000_000;
        $display("tb_lax_json_syntax_checker_top: done, errors");
        $finish;
    end

    // bytes of the document being built, sent front to back
    logic [7:0]  doc_q [$];
    int unsigned bytes_sent;
    int unsigned docs_sent;
    int unsigned dives;
    // no sender gaps for the current document
    bit          calm;

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // status receiver: random stalls with stretches of steady ready
    initial begin
        int unsigned hold_left;
        int unsigned free_left;
        hold_left = 0;
        free_left = 0;
        status_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left != 0) begin
                hold_left--;
                status_bus.ready <= 1'b0;
            end else begin
                status_bus.ready <= 1'b1;
                if (free_left != 0) free_left--;
                else if ($urandom_range(0, 4) == 0) free_left = $urandom_range(20, 200);
                else hold_left = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------- documents

    // append one byte to the document under construction
    function automatic void put_byte(input logic [7:0] b);
        doc_q = {doc_q, b};
    endfunction

    function automatic logic [7:0] blank_pick();
        int unsigned r;
        r = $urandom_range(0, 5);
        // tab, newline, vertical tab, form feed, carriage return or space
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    // optional whitespace where the grammar skips it
    function automatic void add_blanks();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) put_byte(blank_pick());
    endfunction

    // quoted string with random raw bytes and escapes, any byte after a backslash
    function automatic void add_string(input int unsigned max_len);
        logic [7:0] b;
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, max_len)) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) begin
                put_byte(CH_BACKSLASH);
                put_byte(b);
            end else begin
                if (b == CH_QUOTE || b == CH_BACKSLASH) b = CH_LOWER_E;
                put_byte(b);
            end
        end
        put_byte(CH_QUOTE);
    endfunction

    function automatic void add_key(input int unsigned max_len);
        add_string(max_len);
        put_byte(CH_COLON);
        add_blanks();
    endfunction

    // lax number: minus or digit, then any run of digits, dot, e, signs, blanks
    function automatic void add_number();
        int unsigned r;
        if ($urandom_range(0, 3) == 0) put_byte(CH_MINUS);
        else put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        repeat ($urandom_range(0, 5)) begin
            r = $urandom_range(0, 14);
            case (r)
                10:      put_byte(CH_DOT);
                11:      put_byte(CH_LOWER_E);
                12:      put_byte(CH_PLUS);
                13:      put_byte(CH_MINUS);
                14:      put_byte(blank_pick());
                default: put_byte(CH_ZERO + 8'(r));
            endcase
        end
    endfunction

    // true/false/null, now and then with blanks between the letters
    function automatic void add_literal();
        string w;
        case ($urandom_range(0, 2))
            0:       w = "true";
            1:       w = "false";
            default: w = "null";
        endcase
        put_byte(w[0]);
        for (int i = 1; i < w.len(); i++) begin
            if ($urandom_range(0, 7) == 0) put_byte(blank_pick());
            put_byte(w[i]);
        end
        add_blanks();
    endfunction

    // well-formed document with random content; a dive opens containers
    // straight down to nest_goal and then closes them all again
    function automatic void build_document(input int unsigned nest_goal, input bit dive);
        bit open_kind [$];
        bit is_obj;
        bit seeking;
        doc_q.delete();
        add_blanks();
        seeking = 1'b1;
        while (seeking) begin
            if (open_kind.size() < nest_goal && (dive || $urandom_range(0, 2) == 0)) begin
                is_obj = dive ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1));
                put_byte(is_obj ? CH_LBRACE : CH_LBRACKET);
                open_kind = {open_kind, is_obj};
                add_blanks();
                if (!dive && $urandom_range(0, 3) == 0) begin
                    // empty container counts as the value
                    put_byte(is_obj ? CH_RBRACE : CH_RBRACKET);
                    void'(open_kind.pop_back());
                    add_blanks();
                end else begin
                    if (is_obj) add_key(dive ? 1 : 6);
                    continue;
                end
            end else begin
                case ($urandom_range(0, 2))
                    0:       add_string(6);
                    1:       add_number();
                    default: add_literal();
                endcase
            end
            // value complete: close levels or move on to the next element
            seeking = 1'b0;
            while (open_kind.size() != 0 && !seeking) begin
                if (dive || $urandom_range(0, 1) == 0) begin
                    // trailing comma before the closer is accepted
                    if (!dive && $urandom_range(0, 5) == 0) put_byte(CH_COMMA);
                    put_byte(open_kind[$] ? CH_RBRACE : CH_RBRACKET);
                    void'(open_kind.pop_back());
                    add_blanks();
                end else begin
                    put_byte(CH_COMMA);
                    add_blanks();
                    if (open_kind[$]) add_key(6);
                    seeking = 1'b1;
                end
            end
        end
    endfunction

    function automatic logic [7:0] token_pick();
        case ($urandom_range(0, 7))
            0:       return CH_LBRACE;
            1:       return CH_RBRACE;
            2:       return CH_LBRACKET;
            3:       return CH_RBRACKET;
            4:       return CH_QUOTE;
            5:       return CH_COMMA;
            6:       return CH_COLON;
            default: return CH_BACKSLASH;
        endcase
    endfunction

    // break a good document: overwrite, drop, cut short, insert a token, or trail junk
    function automatic void damage_document();
        int unsigned at;
        logic [7:0]  b;
        at = $urandom_range(0, doc_q.size() - 1);
        b  = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0:       doc_q[at] = b;
            1:       if (doc_q.size() > 1) doc_q.delete(at);
            2:       while (doc_q.size() > at + 1) void'(doc_q.pop_back());
            3:       doc_q.insert(at, token_pick());
            default: repeat ($urandom_range(1, 4)) put_byte(b);
        endcase
    endfunction

    function automatic void load_text(input string s);
        doc_q.delete();
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void load_byte(input logic [7:0] b);
        doc_q.delete();
        put_byte(b);
    endfunction

    // ---------------------------------------------------------------- driving

    // one item on the text channel; ready is sampled at the falling edge,
    // where it is settled for the coming rising edge
    task automatic send_text_byte(input logic [7:0] b, input logic last);
        logic        rdy;
        int unsigned gap;
        text_bus.valid       <= 1'b1;
        text_bus.text_byte   <= b;
        text_bus.end_of_text <= last;
        forever begin
            @(negedge clk);
            rdy = text_bus.ready;
            @(posedge clk);
            if (rdy) break;
        end
        bytes_sent++;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            text_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // whole document, end_of_text on its last byte
    task automatic send_document();
        for (int i = 0; i < doc_q.size(); i++)
            send_text_byte(doc_q[i], i == doc_q.size() - 1);
        docs_sent++;
    endtask

    // sender holds off until every status item has come back
    task automatic drain_status();
        text_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int unsigned random_start;
        int unsigned doc_n;
        int unsigned r;
        int unsigned goal;
        text_bus.valid       <= 1'b0;
        text_bus.text_byte   <= ZERO_BYTE;
        text_bus.end_of_text <= 1'b0;
        rst_n                <= 1'b0;
        bytes_sent = 0;
        docs_sent  = 0;
        dives      = 0;
        calm       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed documents
        load_text(" ");            send_document();   // blank document
        load_byte(ZERO_BYTE);      send_document();   // zero byte is ordinary
        load_byte(TOP_BYTE);       send_document();
        load_text("7");            send_document();   // bare number at top level
        load_text("\"\\\"");       send_document();   // escaped quote, string left open
        load_text("[1,]");         send_document();   // trailing comma
        load_text("{}x");          send_document();   // decided early, junk ignored
        load_text("n u");          send_document();   // literal cut off
        load_text("]");            send_document();   // closer with nothing open
        load_text("[\"a\"]");      send_document();

        // random documents: mostly well formed, some damaged, some pure noise,
        // and a few dives near the stack limit, from two levels below to two past it
        random_start = bytes_sent;
        doc_n        = 0;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 3) == 0);
            if (doc_n == 4 || $urandom_range(0, 19) == 0) drain_status();
            r = $urandom_range(0, 99);
            if (doc_n == 2 || doc_n == 11 || r < 3) begin
                if (doc_n == 2) goal = NEST_LIMIT + 1;
                else if (doc_n == 11) goal = NEST_LIMIT;
                else goal = $urandom_range(NEST_LIMIT - 2, NEST_LIMIT + 2);
                build_document(goal, 1'b1);
                dives++;
            end else if (r < 13) begin
                doc_q.delete();
                repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
            end else begin
                build_document($urandom_range(0, 4), 1'b0);
                if ($urandom_range(0, 4) == 0) damage_document();
            end
            send_document();
            doc_n++;
        end

        // let the last status items come home, then a short settle
        text_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("run covered %0d text bytes in %0d documents, %0d of them nesting dives",
                 bytes_sent, docs_sent, dives);
        $display("status items seen: %0d valid, %0d invalid, %0d too deep",
                 valid_seen, invalid_seen, deep_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_lax_json_syntax_checker_top: done, clean");
        end else begin
            $display("tb_lax_json_syntax_checker_top: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/jsc_pkg.sv
hdl/jsc_byte_if.sv
hdl/jsc_status_if.sv
hdl/jsc_stack.sv
hdl/jsc_core.sv
hdl/lax_json_syntax_checker_top.sv
sim/tb_jsc_status_checker.sv
sim/tb_lax_json_syntax_checker_top.sv
